FILE: src/ille_pkg.sv
`default_nettype none

package ille_pkg;

  // Default number of nodes in the store.
  localparam int DEF_CAPACITY = 256;

  // Widths of the transaction fields.
  localparam int POS_W   = 10;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_APPEND   = 2'd1,
    ACT_DELETE   = 2'd2,
    ACT_DEL_LAST = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } rsp_t;

  // Sequencer states.
  typedef enum logic [7:0] {
    SQ_INIT   = 8'b0000_0001,
    SQ_IDLE   = 8'b0000_0010,
    SQ_WALK   = 8'b0000_0100,
    SQ_RD_A   = 8'b0000_1000,
    SQ_RD_B   = 8'b0001_0000,
    SQ_WR_A   = 8'b0010_0000,
    SQ_WR_B   = 8'b0100_0000,
    SQ_FINISH = 8'b1000_0000
  } seq_state_t;

endpackage

`default_nettype wire

FILE: src/indexed_linked_list_engine_unit.sv
`default_nettype none

// Channel   Direction  Payload  Handshake
// req       in         req_t    req_valid / req_stall
// rsp       out        rsp_t    rsp_valid / rsp_stall
//
// After reset the link store is chained into the free list, one node per
// cycle, and the unit stalls requests until that pass is done.
// An insert or delete at position k walks k-1 links, one per cycle, then
// updates links in the RD_A, RD_B, WR_A and WR_B states, so a walk over
// a full list of CAPACITY nodes sets the worst case.
// Requests at position zero, append on a full list and other errors skip
// the walk. A stalled response holds the sequencer in its
// final state; the next request is taken once the result is registered.

module indexed_linked_list_engine_unit
  import ille_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_stall,
  input  wire req_t  req,
  output logic       rsp_valid,
  input  wire logic  rsp_stall,
  output rsp_t       rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic                       ready;
  logic                       out_free;
  logic                       done;
  status_t                    done_status;
  logic [LW-1:0]              done_count;
  logic [LW+COUNT_W-1:0]      count_ext;
  logic [AW-1:0]              rd_addr;
  logic [LW-1:0]              rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [LW-1:0]              wr_link;
  logic                       val_en;
  logic signed [VALUE_W-1:0]  val_data;

  assign req_stall = !ready;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign count_ext = (LW + COUNT_W)'(done_count);

  ille_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .ready       (ready),
    .out_free    (out_free),
    .done        (done),
    .done_status (done_status),
    .done_count  (done_count),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_link     (wr_link),
    .val_en      (val_en),
    .val_data    (val_data)
  );

  ille_node_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_link  (wr_link),
    .val_en   (val_en),
    .val_data (val_data)
  );

  // Output register: holds the result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.status <= done_status;
      rsp.count  <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/ille_node_store.sv
`default_nettype none

module ille_node_store
  import ille_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                              clk,
  input  wire logic [$clog2(CAPACITY)-1:0]       rd_addr,
  output logic      [$clog2(CAPACITY+1)-1:0]     rd_data,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(CAPACITY)-1:0]       wr_addr,
  input  wire logic [$clog2(CAPACITY+1)-1:0]     wr_link,
  input  wire logic                              val_en,
  input  wire logic signed [VALUE_W-1:0]         val_data
);

  localparam int LW = $clog2(CAPACITY + 1);

  logic [LW-1:0]              links [CAPACITY];
  logic signed [VALUE_W-1:0]  vals  [CAPACITY];

  // Link memory: one registered read port, one write port.
  always_ff @(posedge clk) begin
    rd_data <= links[rd_addr];
    if (wr_en) begin
      links[wr_addr] <= wr_link;
    end
  end

  // Element values, written when a node is taken from the free list.
  always_ff @(posedge clk) begin
    if (val_en) begin
      vals[wr_addr] <= val_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/ille_seq.sv
`default_nettype none

module ille_seq
  import ille_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  input  wire req_t                              req,
  output logic                                   ready,
  input  wire logic                              out_free,
  output logic                                   done,
  output status_t                                done_status,
  output logic      [$clog2(CAPACITY+1)-1:0]     done_count,
  output logic      [$clog2(CAPACITY)-1:0]       rd_addr,
  input  wire logic [$clog2(CAPACITY+1)-1:0]     rd_data,
  output logic                                   wr_en,
  output logic      [$clog2(CAPACITY)-1:0]       wr_addr,
  output logic      [$clog2(CAPACITY+1)-1:0]     wr_link,
  output logic                                   val_en,
  output logic signed [VALUE_W-1:0]              val_data
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CW   = LW;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  seq_state_t state, state_next;

  logic [LW-1:0]   head, free_head;
  logic [CW-1:0]   count;
  logic [AW-1:0]   init_idx;
  logic [LW-1:0]   p, nd, tmp, cur;
  logic            chase;
  logic [CW-1:0]   remain;
  logic            is_ins, k_zero;
  status_t         status;
  logic signed [VALUE_W-1:0] value_r;

  logic            accept;
  logic [CMPW-1:0] pos_ext, cnt_ext, eff_pos;
  logic            req_ins;
  status_t         req_status;
  logic [LW-1:0]   cur_eff;

  assign ready  = (state == SQ_IDLE);
  assign accept = ready && req_valid;

  // Request decode: effective position and the status checks.
  always_comb begin
    pos_ext = CMPW'(req.position);
    cnt_ext = CMPW'(count);
    case (req.action)
      ACT_INSERT:   eff_pos = pos_ext;
      ACT_APPEND:   eff_pos = cnt_ext;
      ACT_DELETE:   eff_pos = pos_ext;
      ACT_DEL_LAST: eff_pos = cnt_ext - CMPW'(1);
      default:      eff_pos = pos_ext;
    endcase
    req_ins = (req.action == ACT_INSERT) || (req.action == ACT_APPEND);
    if (req_ins) begin
      if (count == CW'(CAPACITY)) begin
        req_status = STAT_FULL;
      end else if (eff_pos > cnt_ext) begin
        req_status = STAT_RANGE;
      end else begin
        req_status = STAT_OK;
      end
    end else begin
      if (count == '0) begin
        req_status = STAT_EMPTY;
      end else if (eff_pos >= cnt_ext) begin
        req_status = STAT_RANGE;
      end else begin
        req_status = STAT_OK;
      end
    end
  end

  // The walk follows one link per cycle straight from the read data.
  assign cur_eff = chase ? rd_data : cur;

  // Read address of the link memory.
  always_comb begin
    case (state)
      SQ_WALK: rd_addr = cur_eff[AW-1:0];
      SQ_RD_A: begin
        if (is_ins) begin
          rd_addr = free_head[AW-1:0];
        end else if (k_zero) begin
          rd_addr = head[AW-1:0];
        end else begin
          rd_addr = p[AW-1:0];
        end
      end
      SQ_RD_B: rd_addr = is_ins ? p[AW-1:0] : rd_data[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  // Write port of the link and value memories.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_link  = '0;
    val_en   = 1'b0;
    val_data = value_r;
    case (state)
      SQ_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_idx;
        wr_link = LW'(init_idx) + LW'(1);
      end
      SQ_RD_B: begin
        if (!is_ins && k_zero) begin
          wr_en   = 1'b1;
          wr_addr = head[AW-1:0];
          wr_link = free_head;
        end
      end
      SQ_WR_A: begin
        wr_en = 1'b1;
        if (is_ins) begin
          wr_addr = free_head[AW-1:0];
          wr_link = k_zero ? head : rd_data;
          val_en  = 1'b1;
        end else begin
          wr_addr = p[AW-1:0];
          wr_link = rd_data;
        end
      end
      SQ_WR_B: begin
        wr_en = 1'b1;
        if (is_ins) begin
          wr_addr = p[AW-1:0];
          wr_link = free_head;
        end else begin
          wr_addr = nd[AW-1:0];
          wr_link = free_head;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      SQ_INIT: begin
        if (init_idx == AW'(CAPACITY - 1)) begin
          state_next = SQ_IDLE;
        end
      end
      SQ_IDLE: begin
        if (accept) begin
          if (req_status != STAT_OK) begin
            state_next = SQ_FINISH;
          end else if (eff_pos == '0) begin
            state_next = SQ_RD_A;
          end else begin
            state_next = SQ_WALK;
          end
        end
      end
      SQ_WALK: begin
        if (remain == '0) begin
          state_next = SQ_RD_A;
        end
      end
      SQ_RD_A: state_next = SQ_RD_B;
      SQ_RD_B: state_next = (!is_ins && k_zero) ? SQ_FINISH : SQ_WR_A;
      SQ_WR_A: state_next = (is_ins && k_zero) ? SQ_FINISH : SQ_WR_B;
      SQ_WR_B: state_next = SQ_FINISH;
      SQ_FINISH: begin
        if (out_free) begin
          state_next = SQ_IDLE;
        end
      end
      default: state_next = SQ_INIT;
    endcase
  end

  // Result of the transaction and the count after it.
  always_comb begin
    done        = (state == SQ_FINISH) && out_free;
    done_status = status;
    if (status != STAT_OK) begin
      done_count = count;
    end else if (is_ins) begin
      done_count = count + CW'(1);
    end else begin
      done_count = count - CW'(1);
    end
  end

  // Control state: list heads, count and free-list chaining pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SQ_INIT;
      init_idx  <= '0;
      head      <= NIL;
      free_head <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (state == SQ_INIT) begin
        init_idx <= init_idx + AW'(1);
      end
      case (state)
        SQ_RD_B: begin
          if (!is_ins && k_zero) begin
            head      <= rd_data;
            free_head <= head;
          end
        end
        SQ_WR_A: begin
          if (is_ins && k_zero) begin
            head      <= free_head;
            free_head <= tmp;
          end
        end
        SQ_WR_B: begin
          free_head <= is_ins ? tmp : nd;
        end
        SQ_FINISH: begin
          if (out_free) begin
            count <= done_count;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    case (state)
      SQ_IDLE: begin
        if (accept) begin
          is_ins  <= req_ins;
          status  <= req_status;
          k_zero  <= (eff_pos == '0);
          value_r <= req.value;
          cur     <= head;
          chase   <= 1'b0;
          remain  <= CW'(eff_pos - CMPW'(1));
        end
      end
      SQ_WALK: begin
        cur <= cur_eff;
        if (remain == '0) begin
          p <= cur_eff;
        end else begin
          chase  <= 1'b1;
          remain <= remain - CW'(1);
        end
      end
      SQ_RD_B: begin
        tmp <= rd_data;
        nd  <= rd_data;
      end
      default: begin
        chase <= chase;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps

import ille_pkg::*;

// Tracks the list contents as accepted requests arrive and checks each response.
class list_scoreboard;
  int unsigned capacity;
  logic signed [VALUE_W-1:0] contents[$];
  rsp_t expected_rsp[$];
  int errors;
  int requests;
  int responses;
  int status_seen[4];
  int peak_fill;

  function new(int unsigned cap);
    capacity = cap;
    errors = 0;
    requests = 0;
    responses = 0;
    peak_fill = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function int fill();
    return contents.size();
  endfunction

  function int pending();
    return expected_rsp.size();
  endfunction

  // Applies one accepted request to the shadow list and queues its response.
  function void note_request(req_t r);
    status_t st;
    int unsigned pos;
    int unsigned n;
    rsp_t e;
    pos = r.position;
    n = contents.size();
    st = STAT_OK;
    case (r.action)
      ACT_INSERT: begin
        if (n == capacity) st = STAT_FULL;
        else if (pos > n) st = STAT_RANGE;
        else contents.insert(pos, r.value);
      end
      ACT_APPEND: begin
        if (n == capacity) st = STAT_FULL;
        else contents.push_back(r.value);
      end
      ACT_DELETE: begin
        if (n == 0) st = STAT_EMPTY;
        else if (pos >= n) st = STAT_RANGE;
        else contents.delete(pos);
      end
      default: begin
        if (n == 0) st = STAT_EMPTY;
        else void'(contents.pop_back());
      end
    endcase
    e.status = st;
    e.count = COUNT_W'(contents.size());
    expected_rsp.push_back(e);
    requests++;
    status_seen[st]++;
    if (contents.size() > peak_fill) peak_fill = contents.size();
  endfunction

  // Compares one accepted response with the oldest expectation.
  function void check_result(rsp_t r);
    rsp_t e;
    responses++;
    if (expected_rsp.size() == 0) begin
      $error("response with nothing expected: status %s count %0d", r.status.name(), r.count);
      errors++;
      return;
    end
    e = expected_rsp.pop_front();
    if (r.status !== e.status) begin
      $error("status: expected %s, got %s", e.status.name(), r.status.name());
      errors++;
    end
    if (r.count !== e.count) begin
      $error("count: expected %0d, got %0d", e.count, r.count);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CAP = DEF_CAPACITY;
  localparam int LIMIT = 3000000;
  localparam int HOLD_LEN = 600;
  localparam int PHASE_ITEMS = 225;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  list_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  bit growing = 1'b1;

  indexed_linked_list_engine_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle counter guards against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor both channels for transactions.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
    end
  end

  function automatic req_t make_req(action_t a, int unsigned pos, logic signed [31:0] v);
    req_t r;
    r.action = a;
    r.position = pos[POS_W-1:0];
    r.value = v;
    return r;
  endfunction

  // Biased toward legal positions and toward growth or shrinkage of the list.
  function automatic req_t random_req(bit grow, int unsigned fill);
    req_t r;
    int unsigned pick;
    r.position = POS_W'($urandom_range(0, 1023));
    r.value = $urandom;
    pick = $urandom_range(0, 19);
    if (pick == 0) r.value = 32'sh8000_0000;
    else if (pick == 1) r.value = 32'sh7fff_ffff;
    if ($urandom_range(0, 99) < (grow ? 70 : 30)) begin
      r.action = ($urandom_range(0, 1) == 1) ? ACT_INSERT : ACT_APPEND;
    end else begin
      r.action = ($urandom_range(0, 1) == 1) ? ACT_DELETE : ACT_DEL_LAST;
    end
    if ($urandom_range(0, 99) < 85) begin
      if (r.action == ACT_INSERT) r.position = POS_W'($urandom_range(0, fill));
      else if (fill > 0) r.position = POS_W'($urandom_range(0, fill - 1));
    end
    return r;
  endfunction

  // Presents one transaction, with optional idle cycles first, and waits for acceptance.
  task automatic send_item(req_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
  endtask

  // Sender goes quiet until every outstanding response has returned.
  // The monitor samples first so that the last accepted request is on record.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (sb.fill() == CAP) growing = 1'b0;
      else if (sb.fill() == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) < 2) growing = !growing;
      send_item(random_req(growing, sb.fill()));
    end
  endtask

  initial begin
    sb = new(CAP);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list errors, ends of the list, extremes of the fields.
    send_item(make_req(ACT_DELETE, 0, 0));
    send_item(make_req(ACT_DEL_LAST, 0, 0));
    send_item(make_req(ACT_INSERT, 1, 7));
    send_item(make_req(ACT_INSERT, 1023, 7));
    send_item(make_req(ACT_INSERT, 0, 32'sh8000_0000));
    send_item(make_req(ACT_APPEND, 1023, 32'sh7fff_ffff));
    send_item(make_req(ACT_INSERT, 2, -1));
    send_item(make_req(ACT_INSERT, 1, 0));
    send_item(make_req(ACT_INSERT, 5, 3));
    send_item(make_req(ACT_DELETE, 4, 0));
    send_item(make_req(ACT_DELETE, 1023, 0));
    send_item(make_req(ACT_DELETE, 2, 0));
    send_item(make_req(ACT_DEL_LAST, 1023, -1));
    send_item(make_req(ACT_DELETE, 0, 0));
    send_item(make_req(ACT_INSERT, 1, 32'sh5555_5555));
    send_item(make_req(ACT_DEL_LAST, 0, 0));
    send_item(make_req(ACT_DELETE, 0, 0));
    send_item(make_req(ACT_DELETE, 0, 0));
    send_item(make_req(ACT_APPEND, 0, 32'sh2aaa_aaaa));
    send_item(make_req(ACT_DEL_LAST, 0, 0));

    // Fill to capacity; a long receiver hold-off partway backs up the request side.
    for (int i = 0; sb.fill() < CAP; i++) begin
      if (i == 20) hold_req <= hold_req + 1;
      if ($urandom_range(0, 3) == 0) send_item(make_req(ACT_APPEND, 0, $urandom));
      else send_item(make_req(ACT_INSERT, $urandom_range(0, sb.fill()), $urandom));
    end
    send_item(make_req(ACT_INSERT, 1023, 1));
    send_item(make_req(ACT_APPEND, 0, 1));
    send_item(make_req(ACT_INSERT, 0, 1));
    send_item(make_req(ACT_DELETE, CAP, 0));
    send_item(make_req(ACT_DELETE, CAP - 1, 0));
    send_item(make_req(ACT_APPEND, 0, -2));
    send_item(make_req(ACT_DELETE, 0, 0));
    send_item(make_req(ACT_INSERT, CAP - 1, 9));
    wait_drained();

    // Random traffic under each idling pattern.
    run_random(PHASE_ITEMS);
    send_idle_pct = 55;
    run_random(PHASE_ITEMS);
    wait_drained();
    send_idle_pct = 0;
    stall_pct = 55;
    run_random(PHASE_ITEMS);
    send_idle_pct = 12;
    stall_pct = 12;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS);

    wait_drained();
    repeat (300) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("responses: expected %0d more, got 0", sb.pending());
    end
    $display("Ran %0d requests and checked %0d responses, peak list length %0d of %0d.",
             sb.requests, sb.responses, sb.peak_fill, CAP);
    $display("Statuses seen: ok %0d, full %0d, empty %0d, out of range %0d.",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_FULL],
             sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_RANGE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: files.f
src/ille_pkg.sv
src/ille_node_store.sv
src/ille_seq.sv
src/indexed_linked_list_engine_unit.sv
sim/tb.sv
